// ----- rtl/core/weighted_random_row_select_assert.svh -----
// ----------------------------------------------------------------------------
// Weighted random row select - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_ROW_SELECT_ASSERT_SVH
`define WEIGHTED_RANDOM_ROW_SELECT_ASSERT_SVH

// same-cycle implication
`define WRRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define WRRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/wrrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted random row select - package
// Opcodes, status codes, row record and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package wrrs_pkg;

    // request opcodes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_ANY     = 2'd1;
    localparam logic [1:0] OP_EXCLUDE = 2'd2;
    localparam logic [1:0] OP_ALLOW   = 2'd3;

    // response status codes
    localparam logic [1:0] ST_WRITTEN = 2'd0;
    localparam logic [1:0] ST_CHOSEN  = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    // field widths
    localparam int ROW_IDX_W = 6;
    localparam int WIN_W     = 16;
    localparam int RTYPE_W   = 4;
    localparam int MASK_W    = 16;
    localparam int RND_W     = 32;
    localparam int ROWS_W    = 7;
    localparam int WEIGHT_W  = 15;   // stored weight is 1 .. 32767

    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = WEIGHT_W'(1);

    // one table row
    typedef struct packed {
        logic [RTYPE_W-1:0]  row_type;
        logic [WEIGHT_W-1:0] weight;
    } t_wrrs_row;

    // controller to datapath
    typedef struct packed {
        logic       load;       // capture request, clear accumulators
        logic       wr_en;      // write a row
        logic       walk_clr;   // restart table walk
        logic       sum_en;     // first pass: totals
        logic       scan_en;    // second pass: cumulative search
        logic       sel;        // settle pick mode and total
        logic       mul;        // random * total
        logic       roll;       // form roll, clear search accumulator
        logic       out_load;   // load response register
        logic [1:0] out_status;
    } t_wrrs_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic hit;
        logic empty;
    } t_wrrs_stat;

endpackage

`default_nettype wire

// ----- rtl/core/wrrs_dpath.sv -----
// ----------------------------------------------------------------------------
// Weighted random row select - datapath
// Row memory, table walker, weight accumulators, roll multiplier, response.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrs_dpath #(
    parameter int TABLE_ROWS = 64,
    parameter int TYPE_COUNT = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wrrs_pkg::t_wrrs_cmd                  i_cmd,
    output wrrs_pkg::t_wrrs_stat                 o_stat,
    input  logic [1:0]                           i_opcode,
    input  logic [wrrs_pkg::ROW_IDX_W-1:0]       i_row_index,
    input  logic signed [wrrs_pkg::WIN_W-1:0]    i_row_weight_in,
    input  logic [wrrs_pkg::RTYPE_W-1:0]         i_row_type_in,
    input  logic [wrrs_pkg::MASK_W-1:0]          i_type_mask,
    input  logic [wrrs_pkg::RND_W-1:0]           i_random_value,
    input  logic                                 i_cfg_wr,
    input  logic [wrrs_pkg::ROWS_W-1:0]          i_cfg_data,
    output logic [1:0]                           o_status,
    output logic [wrrs_pkg::ROW_IDX_W-1:0]       o_chosen_row
);
    import wrrs_pkg::*;

    localparam int AW     = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int CNT_W  = $clog2(TABLE_ROWS + 1);
    localparam int TOT_W  = WEIGHT_W + CNT_W;
    localparam int PROD_W = RND_W + TOT_W;

    t_wrrs_row              r_mem [TABLE_ROWS];
    t_wrrs_row              r_rd;
    logic [ROWS_W-1:0]      r_rows;
    logic [CNT_W-1:0]       r_ptr;
    logic                   r_lag_v;
    logic [AW-1:0]          r_lag_row;
    logic [1:0]             r_mode;
    logic [MASK_W-1:0]      r_mask;
    logic [RND_W-1:0]       r_rnd;
    logic [TOT_W-1:0]       r_tot_all;
    logic [TOT_W-1:0]       r_tot_f;
    logic [CNT_W-1:0]       r_cnt_f;
    logic [TOT_W-1:0]       r_total;
    logic [PROD_W-1:0]      r_prod;
    logic [TOT_W-1:0]       r_roll;
    logic [TOT_W-1:0]       r_acc;
    logic [AW-1:0]          r_chosen;
    logic [1:0]             r_out_status;
    logic [ROW_IDX_W-1:0]   r_out_row;

    logic [MASK_W-1:0]      w_type_bits;
    logic [CNT_W-1:0]       w_n;
    logic                   w_walk_en;
    logic                   w_pass;
    logic [TOT_W-1:0]       w_wt;
    logic [TOT_W-1:0]       w_acc_next;
    logic [1:0]             w_eff_mode;
    logic [TOT_W-1:0]       w_eff_total;
    logic                   w_eff_none;
    t_wrrs_row              w_wr_row;
    logic                   w_wr_ok;

    // row filter by type
    function automatic logic row_pass(input logic [1:0] mode,
                                      input logic [RTYPE_W-1:0] t,
                                      input logic [MASK_W-1:0] m);
        logic in_m;
        in_m = m[t];
        case (mode)
            OP_EXCLUDE: row_pass = !in_m;
            OP_ALLOW:   row_pass = (m == '0) || in_m;
            default:    row_pass = 1'b1;
        endcase
    endfunction

    // mask bits for types that exist
    always_comb begin
        for (int b = 0; b < MASK_W; b++) begin
            w_type_bits[b] = (b < TYPE_COUNT);
        end
    end

    // rows in use, saturated to the table
    assign w_n = (32'(r_rows) > TABLE_ROWS) ? CNT_W'(TABLE_ROWS) : CNT_W'(r_rows);

    // write data: weights below 1 stored as 1
    always_comb begin
        w_wr_row.row_type = i_row_type_in;
        if (i_row_weight_in == '0 || i_row_weight_in[WIN_W-1]) begin
            w_wr_row.weight = WEIGHT_MIN;
        end else begin
            w_wr_row.weight = i_row_weight_in[WEIGHT_W-1:0];
        end
    end
    assign w_wr_ok = (32'(i_row_index) < TABLE_ROWS);

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_wr_ok) begin
            r_mem[AW'(i_row_index)] <= w_wr_row;
        end
        if (w_walk_en && (r_ptr < w_n)) begin
            r_rd <= r_mem[r_ptr[AW-1:0]];
        end
    end

    // filter and accumulate on the row coming out of memory
    assign w_walk_en  = i_cmd.sum_en | i_cmd.scan_en;
    assign w_pass     = row_pass(r_mode, r_rd.row_type, r_mask);
    assign w_wt       = TOT_W'(r_rd.weight);
    assign w_acc_next = r_acc + w_wt;

    // effective pick mode: exclude with nothing left falls back to all rows
    always_comb begin
        if (r_mode == OP_EXCLUDE && r_cnt_f == '0) begin
            w_eff_mode  = OP_ANY;
            w_eff_total = r_tot_all;
            w_eff_none  = (w_n == '0);
        end else if (r_mode == OP_ANY) begin
            w_eff_mode  = OP_ANY;
            w_eff_total = r_tot_all;
            w_eff_none  = (w_n == '0);
        end else begin
            w_eff_mode  = r_mode;
            w_eff_total = r_tot_f;
            w_eff_none  = (r_cnt_f == '0);
        end
    end

    // status to controller
    assign o_stat.walk_done = (r_ptr == w_n) && !r_lag_v;
    assign o_stat.hit       = i_cmd.scan_en && r_lag_v && w_pass && (r_roll <= w_acc_next);
    assign o_stat.empty     = w_eff_none || (w_eff_total == '0);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else if (i_cfg_wr) begin
            r_rows <= i_cfg_data;
        end
    end

    // table walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_lag_v <= 1'b0;
        end else if (i_cmd.load || i_cmd.walk_clr) begin
            r_ptr   <= '0;
            r_lag_v <= 1'b0;
        end else if (w_walk_en) begin
            if (r_ptr < w_n) begin
                r_ptr   <= r_ptr + CNT_W'(1);
                r_lag_v <= 1'b1;
            end else begin
                r_lag_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_walk_en) begin
            r_lag_row <= r_ptr[AW-1:0];
        end
    end

    // request capture, totals, roll and search
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_opcode;
            r_mask    <= i_type_mask & w_type_bits;
            r_rnd     <= i_random_value;
            r_tot_all <= '0;
            r_tot_f   <= '0;
            r_cnt_f   <= '0;
            r_chosen  <= '0;
        end else begin
            if (i_cmd.sum_en && r_lag_v) begin
                r_tot_all <= r_tot_all + w_wt;
                if (w_pass) begin
                    r_tot_f <= r_tot_f + w_wt;
                    r_cnt_f <= r_cnt_f + CNT_W'(1);
                end
            end
            if (i_cmd.sel) begin
                r_mode  <= w_eff_mode;
                r_total <= w_eff_total;
            end
            if (o_stat.hit) begin
                r_chosen <= r_lag_row;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_rnd) * PROD_W'(r_total);
        end
        if (i_cmd.roll) begin
            r_roll <= r_prod[PROD_W-1:RND_W] + TOT_W'(WEIGHT_MIN);
            r_acc  <= '0;
        end else if (i_cmd.scan_en && r_lag_v && w_pass) begin
            r_acc <= w_acc_next;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_row    <= (i_cmd.out_status == ST_CHOSEN) ? ROW_IDX_W'(r_chosen) : '0;
        end
    end

    assign o_status     = r_out_status;
    assign o_chosen_row = r_out_row;

endmodule

`default_nettype wire

// ----- rtl/core/wrrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Weighted random row select - controller
// Sequences write and pick requests and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_opcode,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  wrrs_pkg::t_wrrs_stat  i_stat,
    output wrrs_pkg::t_wrrs_cmd   o_cmd
);
    import wrrs_pkg::*;

    `include "weighted_random_row_select_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ROLL = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_resp, n_resp;
    logic       r_out_valid, n_out_valid;
    logic       w_in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_resp      = r_resp;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.out_status = r_resp;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_opcode == OP_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                        n_resp      = ST_WRITTEN;
                        n_state     = S_RESP;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.sel = 1'b1;
                if (i_stat.empty) begin
                    n_resp  = ST_NONE;
                    n_state = S_RESP;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ROLL;
            end
            S_ROLL: begin
                o_cmd.roll     = 1'b1;
                o_cmd.walk_clr = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.hit) begin
                    n_resp  = ST_CHOSEN;
                    n_state = S_RESP;
                end else if (i_stat.walk_done) begin
                    n_resp  = ST_NONE;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                // hand over once the response register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_resp      <= ST_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_resp      <= n_resp;
            r_out_valid <= n_out_valid;
        end
    end

    // assertions
    `WRRS_ASSERT_NEXT(a_accept_busy, w_in_acc, !o_in_ready)
    `WRRS_ASSERT_NEXT(a_hit_resp, (r_state == S_SCAN) && i_stat.hit, r_state == S_RESP)
    `WRRS_ASSERT_NEXT(a_empty_resp, (r_state == S_SEL) && i_stat.empty,
                      (r_state == S_RESP) && (r_resp == ST_NONE))
    `WRRS_ASSERT_SAME(a_load_free, o_cmd.out_load, !r_out_valid || i_out_ready)

endmodule

`default_nettype wire

// ----- rtl/core/weighted_random_row_select.sv -----
// ----------------------------------------------------------------------------
// Weighted random row select - top level
// Roulette-wheel row selection over a typed, weighted row table.
// ----------------------------------------------------------------------------
// One request at a time. A row write is stored as it is accepted. A pick
// walks the first n = min(rows_in_use, TABLE_ROWS) rows of the row memory
// twice at one row per cycle, once to total the weights (all rows and the
// filtered ones) and once to accumulate up to the roll, and the second walk
// stops at the chosen row. A new request is taken while the previous
// response still waits on the output. The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_random_row_select #(
    parameter int TABLE_ROWS = 64,
    parameter int TYPE_COUNT = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_opcode,
    input  logic [wrrs_pkg::ROW_IDX_W-1:0]       i_row_index,
    input  logic signed [wrrs_pkg::WIN_W-1:0]    i_row_weight_in,
    input  logic [wrrs_pkg::RTYPE_W-1:0]         i_row_type_in,
    input  logic [wrrs_pkg::MASK_W-1:0]          i_type_mask,
    input  logic [wrrs_pkg::RND_W-1:0]           i_random_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic [wrrs_pkg::ROW_IDX_W-1:0]       o_chosen_row,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wrrs_pkg::ROWS_W-1:0]          i_cfg_data
);
    import wrrs_pkg::*;

    t_wrrs_cmd  w_cmd;
    t_wrrs_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // controller
    wrrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath
    wrrs_dpath #(
        .TABLE_ROWS (TABLE_ROWS),
        .TYPE_COUNT (TYPE_COUNT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_opcode        (i_opcode),
        .i_row_index     (i_row_index),
        .i_row_weight_in (i_row_weight_in),
        .i_row_type_in   (i_row_type_in),
        .i_type_mask     (i_type_mask),
        .i_random_value  (i_random_value),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_status        (o_status),
        .o_chosen_row    (o_chosen_row)
    );

endmodule

`default_nettype wire
